// ===== src/lqs_pkg.sv =====
// ----------------------------------------------------------------------------
// lqs_pkg
// Shared types and constants for the linear queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lqs_pkg;

    localparam int DEPTH = 64;
    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REQW  = 2;
    localparam int DATAW = 32;
    localparam int STW   = 2;
    localparam int POSW  = 7;

    function automatic int f_levels(input int n);
        int lvl;
        int cap;
        lvl = 1;
        cap = 8;
        for (int k = 0; k < 6; k++) begin
            if (cap < n) begin
                cap = cap * 8;
                lvl = lvl + 1;
            end
        end
        return lvl;
    endfunction

    // priority tree over the per-cell match bits, radix 8
    localparam int FLVL  = f_levels(DEPTH);
    localparam int NLEAF = 8 ** FLVL;
    localparam int FIDXW = 3 * FLVL;
    localparam int WAITW = $clog2(FLVL + 1);
    localparam int MAXW0 = (IDXW > FIDXW) ? IDXW : FIDXW;
    localparam int SUMW  = ((MAXW0 > POSW) ? MAXW0 : POSW) + 1;

    typedef enum logic [REQW-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2
    } t_req;

    typedef enum logic [STW-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic                    srch;
        logic signed [DATAW-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        t_status                 status;
        logic signed [DATAW-1:0] data_out;
        logic [POSW-1:0]         position;
    } t_res;

endpackage

`default_nettype wire

// ===== src/lqs_req_if.sv =====
// ----------------------------------------------------------------------------
// lqs_req_if
// Request channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lqs_req_if;
    logic                            valid;
    logic                            ready;
    logic [lqs_pkg::REQW-1:0]        req_type;
    logic signed [lqs_pkg::DATAW-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ===== src/lqs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lqs_rsp_if
// Result channel: status, dequeued value and search position.
// ----------------------------------------------------------------------------
`default_nettype none

interface lqs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [lqs_pkg::STW-1:0]          status;
    logic signed [lqs_pkg::DATAW-1:0] data_out;
    logic [lqs_pkg::POSW-1:0]         position;

    modport source (output valid, output status, output data_out, output position,
                    input ready);
    modport sink   (input valid, input status, input data_out, input position,
                    output ready);
endinterface

`default_nettype wire

// ===== src/lqs_cell.sv =====
// ----------------------------------------------------------------------------
// lqs_cell
// One queue slot: holds a value and an occupied flag, takes an insert when
// it is the first free cell, shifts toward the head on delete, and compares
// its value against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lqs_pkg::t_cell_ctl               i_ctl,
    input  wire logic                             i_prv_vld,
    input  wire logic                             i_nxt_vld,
    input  wire logic signed [lqs_pkg::DATAW-1:0] i_nxt_val,
    output logic signed [lqs_pkg::DATAW-1:0]      o_val,
    output logic                                  o_vld,
    output logic                                  o_match
);

    logic                             r_vld;
    logic signed [lqs_pkg::DATAW-1:0] r_val;
    logic                             r_match;
    logic                             w_take;

    assign w_take = i_ctl.ins && i_prv_vld && !r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.del) begin
            r_vld <= i_nxt_vld;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.del) begin
            r_val <= i_nxt_val;
        end else if (w_take) begin
            r_val <= i_ctl.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.srch) begin
            r_match <= r_vld && (r_val == i_ctl.key);
        end
    end

    assign o_val   = r_val;
    assign o_vld   = r_vld;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== src/lqs_find.sv =====
// ----------------------------------------------------------------------------
// lqs_find
// Registered radix-8 priority tree: index of the lowest set match bit.
// Each tree level is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_find (
    input  wire logic                         i_clk,
    input  wire logic [lqs_pkg::DEPTH-1:0]    i_match,
    output logic                              o_found,
    output logic [lqs_pkg::FIDXW-1:0]         o_idx
);

    localparam int L  = lqs_pkg::FLVL;
    localparam int NL = lqs_pkg::NLEAF;
    localparam int W  = lqs_pkg::FIDXW;
    localparam int NN = NL / 8;

    logic [NL-1:0] w_leaf;
    logic          r_fnd [1:L][NN];
    logic [W-1:0]  r_idx [1:L][NN];

    assign w_leaf = NL'(i_match);

    for (genvar l = 1; l <= L; l++) begin : g_lvl
        for (genvar n = 0; n < 8 ** (L - l); n++) begin : g_node
            if (l == 1) begin : g_leaf
                always_ff @(posedge i_clk) begin
                    r_fnd[l][n] <= 1'b0;
                    r_idx[l][n] <= '0;
                    for (int c = 7; c >= 0; c--) begin
                        if (w_leaf[8*n + c]) begin
                            r_fnd[l][n] <= 1'b1;
                            r_idx[l][n] <= W'(c);
                        end
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    r_fnd[l][n] <= 1'b0;
                    r_idx[l][n] <= '0;
                    for (int c = 7; c >= 0; c--) begin
                        if (r_fnd[l-1][8*n + c]) begin
                            r_fnd[l][n] <= 1'b1;
                            r_idx[l][n] <= (W'(c) << (3 * (l - 1))) | r_idx[l-1][8*n + c];
                        end
                    end
                end
            end
        end
    end

    assign o_found = r_fnd[L][0];
    assign o_idx   = r_idx[L][0];

endmodule

`default_nettype wire

// ===== src/linear_queue_with_search_core.sv =====
// ----------------------------------------------------------------------------
// linear_queue_with_search_core
// Non-wrapping array queue with insert, delete and search, built as a row
// of slot cells that shift toward the head on delete.
//
//   channel  dir  port    fields
//   -------  ---  ------  ---------------------------------
//   request  in   i_req   req_type[1:0], value[31:0] signed
//   result   out  o_rsp   status[1:0], data_out[31:0] signed, position[6:0]
//
// Insert, delete and unused codes write their result when accepted. A search
// runs a compare in the cells, then each level of the radix-8 priority
// tree in turn, then the result write.
// One item is in work at a time; a two-entry result buffer lets items be
// taken while results wait. Synchronous active-low reset empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_queue_with_search_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lqs_req_if.sink    i_req,
    lqs_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SRCH = 2'b10
    } t_state;

    t_state                               r_state, n_state;
    logic [lqs_pkg::IDXW-1:0]             r_head, n_head;
    logic [lqs_pkg::IDXW-1:0]             r_tail, n_tail;
    logic                                 r_empty, n_empty;
    logic [lqs_pkg::WAITW-1:0]            r_wait, n_wait;

    lqs_pkg::t_res                        r_q [2];
    logic                                 r_wp, r_rp;
    logic [1:0]                           r_cnt;

    lqs_pkg::t_cell_ctl                   w_ctl;
    lqs_pkg::t_req                        w_req;
    lqs_pkg::t_res                        w_res;
    logic                                 w_acc, w_push, w_pop;
    logic [lqs_pkg::DEPTH-1:0]            w_vld;
    logic [lqs_pkg::DEPTH-1:0]            w_match;
    logic signed [lqs_pkg::DATAW-1:0]     w_val [lqs_pkg::DEPTH];
    logic                                 w_found;
    logic [lqs_pkg::FIDXW-1:0]            w_fidx;
    logic [lqs_pkg::SUMW-1:0]             w_sum;

    // ---- cell row ----
    for (genvar j = 0; j < lqs_pkg::DEPTH; j++) begin : g_cell
        logic                             w_prv;
        logic                             w_nv;
        logic signed [lqs_pkg::DATAW-1:0] w_nval;
        if (j == 0) begin : g_first
            assign w_prv = 1'b1;
        end else begin : g_mid
            assign w_prv = w_vld[j-1];
        end
        if (j == lqs_pkg::DEPTH - 1) begin : g_last
            assign w_nv   = 1'b0;
            assign w_nval = '0;
        end else begin : g_nxt
            assign w_nv   = w_vld[j+1];
            assign w_nval = w_val[j+1];
        end
        lqs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_prv_vld (w_prv),
            .i_nxt_vld (w_nv),
            .i_nxt_val (w_nval),
            .o_val     (w_val[j]),
            .o_vld     (w_vld[j]),
            .o_match   (w_match[j])
        );
    end

    lqs_find u_find (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_found (w_found),
        .o_idx   (w_fidx)
    );

    // ---- control ----
    assign i_req.ready = (r_state == S_IDLE) && (r_cnt != 2'd2);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_req       = lqs_pkg::t_req'(i_req.req_type);
    assign w_sum       = lqs_pkg::SUMW'(r_head) + lqs_pkg::SUMW'(w_fidx)
                       + lqs_pkg::SUMW'(1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_wait    = r_wait;
        w_ctl     = '{ins: 1'b0, del: 1'b0, srch: 1'b0, key: i_req.value};
        w_res     = '{status: lqs_pkg::ST_OK, data_out: '0, position: '0};
        w_push    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_req)
                        lqs_pkg::REQ_INSERT: begin
                            w_push = 1'b1;
                            if (!r_empty &&
                                r_tail == lqs_pkg::IDXW'(lqs_pkg::DEPTH - 1)) begin
                                w_res.status = lqs_pkg::ST_OVERFLOW;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_empty   = 1'b0;
                                if (r_empty) begin
                                    n_head = '0;
                                    n_tail = '0;
                                end else begin
                                    n_tail = r_tail + 1'b1;
                                end
                            end
                        end
                        lqs_pkg::REQ_DELETE: begin
                            w_push = 1'b1;
                            if (r_empty) begin
                                w_res.status = lqs_pkg::ST_UNDERFLOW;
                            end else begin
                                w_ctl.del      = 1'b1;
                                w_res.data_out = w_val[0];
                                if (r_head >= r_tail) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_head = r_head + 1'b1;
                                end
                            end
                        end
                        lqs_pkg::REQ_SEARCH: begin
                            w_ctl.srch = 1'b1;
                            n_wait     = lqs_pkg::WAITW'(lqs_pkg::FLVL);
                            n_state    = S_SRCH;
                        end
                        default: begin
                            w_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_wait == '0) begin
                    w_push  = 1'b1;
                    n_state = S_IDLE;
                    if (w_found) begin
                        w_res.position = w_sum[lqs_pkg::POSW-1:0];
                    end else begin
                        w_res.status = lqs_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    n_wait = r_wait - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_wait  <= n_wait;
        end
    end

    // ---- result buffer ----
    assign w_pop = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign o_rsp.valid    = (r_cnt != 2'd0);
    assign o_rsp.status   = r_q[r_rp].status;
    assign o_rsp.data_out = r_q[r_rp].data_out;
    assign o_rsp.position = r_q[r_rp].position;

    // ---- checks ----
    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (w_vld == '0))
        else $error("empty queue with occupied cells");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> ($countones(w_vld) == (int'(r_tail) - int'(r_head) + 1)))
        else $error("cell occupancy disagrees with head/tail");

    a_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt != 2'd2 || w_pop))
        else $error("result buffer overrun");

    a_srch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (!w_ctl.ins && !w_ctl.del && !w_ctl.srch))
        else $error("cells changed during search");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for linear_queue_with_search_core. A shadow copy of the queue
// predicts the result of each accepted request: insert, delete, search and
// the unused code. Results are checked in order, field by field. A short
// directed run covers the empty queue, the extreme values and first-match
// search. Random phases then fill the queue toward overflow, drain it toward
// empty, or mix all three operations. Random gaps and stalls are applied on
// both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lqs_pkg::REQW-1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_ITEMS  = 1150;

    class queue_shadow;
        logic [lqs_pkg::DATAW-1:0] slot [lqs_pkg::DEPTH];
        int                        head;
        int                        tail;
        bit                        empty;
        lqs_pkg::t_res             expected_rsp [$];
        int                        n_fail;

        function new();
            head   = 0;
            tail   = 0;
            empty  = 1'b1;
            n_fail = 0;
        endfunction

        function int occupancy();
            return empty ? 0 : tail - head + 1;
        endfunction

        function logic [lqs_pkg::DATAW-1:0] pick_stored();
            return slot[head + $urandom_range(0, tail - head)];
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void note_request(input logic [lqs_pkg::REQW-1:0] code,
                                   input logic [lqs_pkg::DATAW-1:0] val);
            lqs_pkg::t_res r;
            bit            found;
            r.status   = lqs_pkg::ST_OK;
            r.data_out = '0;
            r.position = '0;
            found      = 1'b0;
            case (code)
                lqs_pkg::REQ_INSERT: begin
                    if (!empty && tail >= lqs_pkg::DEPTH - 1) begin
                        r.status = lqs_pkg::ST_OVERFLOW;
                    end else begin
                        if (empty) begin
                            head  = 0;
                            tail  = 0;
                            empty = 1'b0;
                        end else begin
                            tail++;
                        end
                        slot[tail] = val;
                    end
                end
                lqs_pkg::REQ_DELETE: begin
                    if (empty) begin
                        r.status = lqs_pkg::ST_UNDERFLOW;
                    end else begin
                        r.data_out = slot[head];
                        if (head >= tail) begin
                            head  = 0;
                            tail  = 0;
                            empty = 1'b1;
                        end else begin
                            head++;
                        end
                    end
                end
                lqs_pkg::REQ_SEARCH: begin
                    r.status = lqs_pkg::ST_NOT_FOUND;
                    if (!empty) begin
                        for (int k = head; k <= tail && !found; k++) begin
                            if (slot[k] == val) begin
                                found      = 1'b1;
                                r.status   = lqs_pkg::ST_OK;
                                r.position = lqs_pkg::POSW'(k + 1);
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_rsp.push_back(r);
        endfunction

        task report(input string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            n_fail++;
        endtask

        task check_result(input logic [lqs_pkg::STW-1:0] st,
                          input logic [lqs_pkg::DATAW-1:0] dout,
                          input logic [lqs_pkg::POSW-1:0] pos);
            lqs_pkg::t_res want;
            if (expected_rsp.size() == 0) begin
                report($sformatf("unexpected result status=%0d data=%h pos=%0d",
                                 st, dout, pos));
            end else begin
                want = expected_rsp.pop_front();
                if (st !== want.status)
                    report($sformatf("status %0d, want %0d", st, want.status));
                if (dout !== want.data_out)
                    report($sformatf("data_out %h, want %h", dout, want.data_out));
                if (pos !== want.position)
                    report($sformatf("position %0d, want %0d", pos, want.position));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   tx_steady;
    bit   rx_steady;
    int   hold_cnt;
    int   idle_cycles;

    queue_shadow sb;

    lqs_req_if req_ch ();
    lqs_rsp_if rsp_ch ();

    linear_queue_with_search_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [lqs_pkg::DATAW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1: return lqs_pkg::DATAW'($urandom_range(0, 7)) - lqs_pkg::DATAW'(4);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls on ready
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt     <= hold_cnt - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
                hold_cnt <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.status, rsp_ch.data_out, rsp_ch.position);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [lqs_pkg::REQW-1:0] code,
                             input logic [lqs_pkg::DATAW-1:0] val);
        int gap;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.value    <= val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(code, val);
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [lqs_pkg::REQW-1:0]  dir_code [25];
        logic [lqs_pkg::DATAW-1:0] dir_val  [25];
        logic [lqs_pkg::REQW-1:0]  code;
        logic [lqs_pkg::DATAW-1:0] val;
        int                        n_items;
        int                        len;
        int                        roll;
        int                        ins_pct;
        int                        del_pct;

        sb              = new();
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = lqs_pkg::REQ_INSERT;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        hold_cnt        = 0;
        idle_cycles     = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;

        dir_code = '{lqs_pkg::REQ_SEARCH, lqs_pkg::REQ_DELETE, REQ_UNUSED,
                     lqs_pkg::REQ_INSERT, lqs_pkg::REQ_INSERT, lqs_pkg::REQ_INSERT,
                     lqs_pkg::REQ_INSERT, lqs_pkg::REQ_INSERT, lqs_pkg::REQ_SEARCH,
                     lqs_pkg::REQ_SEARCH, lqs_pkg::REQ_SEARCH, REQ_UNUSED,
                     lqs_pkg::REQ_DELETE, lqs_pkg::REQ_SEARCH, lqs_pkg::REQ_DELETE,
                     lqs_pkg::REQ_DELETE, lqs_pkg::REQ_DELETE, lqs_pkg::REQ_DELETE,
                     lqs_pkg::REQ_DELETE, lqs_pkg::REQ_INSERT, lqs_pkg::REQ_SEARCH,
                     lqs_pkg::REQ_INSERT, lqs_pkg::REQ_SEARCH, lqs_pkg::REQ_DELETE,
                     lqs_pkg::REQ_DELETE};
        dir_val  = '{32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_3039, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h5555_5555,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h0000_0000,
                     32'h0000_0000};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 25; i++)
            send_item(dir_code[i], dir_val[i]);

        // phases: fill toward overflow, drain to empty, or mixed
        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            case ($urandom_range(0, 2))
                0: begin ins_pct = 70; del_pct = 10; end
                1: begin ins_pct = 15; del_pct = 60; end
                default: begin ins_pct = 40; del_pct = 35; end
            endcase
            len       = $urandom_range(20, 150);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len && n_items < RAND_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    code = REQ_UNUSED;
                else if (roll < 2 + ins_pct)
                    code = lqs_pkg::REQ_INSERT;
                else if (roll < 2 + ins_pct + del_pct)
                    code = lqs_pkg::REQ_DELETE;
                else
                    code = lqs_pkg::REQ_SEARCH;
                if (code == lqs_pkg::REQ_SEARCH && sb.occupancy() > 0 &&
                    $urandom_range(0, 1) == 1)
                    val = sb.pick_stored();
                else
                    val = pick_value();
                send_item(code, val);
                if (code != REQ_UNUSED)
                    n_items++;
            end
        end
        req_ch.valid <= 1'b0;
        rx_steady    = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== linear_queue_with_search_core.f =====
src/lqs_pkg.sv
src/lqs_req_if.sv
src/lqs_rsp_if.sv
src/lqs_cell.sv
src/lqs_find.sv
src/linear_queue_with_search_core.sv
test/tb.sv
